// ----- rtl/modular_exponentiation_macros.svh -----
// Assertion macros shared by the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define MODEXP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define MODEXP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/modexp_pkg.sv -----
// Package with widths and interface types of the modular exponentiation block.
`timescale 1ns / 1ps
`default_nettype none

package modexp_pkg;

  // Operand width of the arithmetic; ports stay at the field width.
  localparam int WIDTH   = 32;
  localparam int FIELD_W = 32;
  localparam int CNT_W   = $clog2(WIDTH);

  // Request to the shared modular multiplier.
  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
  } mm_req_t;

  // Status back from the shared modular multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

`default_nettype wire

// ----- rtl/modular_exponentiation.sv -----
// Top level: square-and-multiply modular exponentiation over a shared multiplier.
//
// Usage:
//  - Config channel (cfg_valid/cfg_ready, data modulus) sets the modulus n,
//    reset value 21. cfg_ready is always high; write it only while idle.
//  - Input channel (in_valid/in_ready) takes one item {base, exponent}.
//    in_ready is high only while the sequencer is idle.
//  - Output channel (out_valid/out_ready) returns result = base^exponent mod n.
//  - Each modular multiply runs on the bit-serial multiplier: a load, then
//    one multiplier bit per cycle. An item runs one reduction of the base,
//    32 squarings and one multiply per set exponent bit. Items are worked
//    one at a time.
//  - A modulus of 0 or 1 gives 0 without running the multiplier.
//  - The result sits in an output register; a stalled receiver holds it and
//    the block may accept the next item meanwhile, but it waits at the end
//    of that item until the output register is free.
//  - Reset (rst, synchronous) drops any item in flight, empties the output
//    register and restores the modulus to 21.
`timescale 1ns / 1ps
`default_nettype none
`include "modular_exponentiation_macros.svh"

module modular_exponentiation
  import modexp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [FIELD_W-1:0] modulus,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FIELD_W-1:0] base,
  input  logic [FIELD_W-1:0] exponent,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] result
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_SQUARE = 3'd2;
  localparam logic [2:0] S_MULT   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [FIELD_W-1:0] mod_reg;
  logic [WIDTH-1:0]   n;
  logic [WIDTH-1:0]   ebits;
  logic [WIDTH-1:0]   breg;
  logic [WIDTH-1:0]   r;
  logic [CNT_W-1:0]   bitcnt;

  mm_req_t            req;
  mm_stat_t           stat;
  logic [WIDTH-1:0]   prod;

  logic               in_acc;
  logic               mod_small;
  logic               last_bit;
  logic               next_bit;
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign mod_small = (WIDTH'(mod_reg) <= WIDTH'(1));
  assign last_bit  = (bitcnt == '0);
  assign out_free  = !out_valid || out_ready;

  // Advance to the next exponent bit after its square (bit clear) or multiply.
  assign next_bit = stat.done &&
                    (((state == S_SQUARE) && !ebits[WIDTH-1]) || (state == S_MULT));

  // Sequencer: pick the next operation and its operands for the shared unit.
  always_comb begin
    state_next = state;
    req.start  = 1'b0;
    req.a      = prod;
    req.b      = prod;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (mod_small) begin
            state_next = S_DONE;
          end else begin
            // base mod n as 1 * base
            req.start  = 1'b1;
            req.a      = WIDTH'(1);
            req.b      = WIDTH'(base);
            state_next = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (stat.done) begin
          // first square of the running value 1
          req.start  = 1'b1;
          req.a      = WIDTH'(1);
          req.b      = WIDTH'(1);
          state_next = S_SQUARE;
        end
      end
      S_SQUARE: begin
        if (stat.done) begin
          if (ebits[WIDTH-1]) begin
            req.start  = 1'b1;
            req.b      = breg;
            state_next = S_MULT;
          end else if (last_bit) begin
            state_next = S_DONE;
          end else begin
            req.start  = 1'b1;
          end
        end
      end
      S_MULT: begin
        if (stat.done) begin
          if (last_bit) begin
            state_next = S_DONE;
          end else begin
            req.start  = 1'b1;
            state_next = S_SQUARE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mod_reg   <= FIELD_W'(21);
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        mod_reg <= modulus;
      end
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers: hold operands for the item in flight.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      n      <= WIDTH'(mod_reg);
      ebits  <= WIDTH'(exponent);
      bitcnt <= CNT_W'(WIDTH - 1);
      r      <= '0;
    end
    if ((state == S_REDUCE) && stat.done) begin
      breg <= prod;
    end
    if (((state == S_SQUARE) || (state == S_MULT)) && stat.done) begin
      r <= prod;
    end
    if (next_bit && !last_bit) begin
      ebits  <= {ebits[WIDTH-2:0], 1'b0};
      bitcnt <= bitcnt - 1'b1;
    end
    if ((state == S_DONE) && out_free) begin
      result <= FIELD_W'(r);
    end
  end

  modexp_mulmod u_mulmod (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .n    (n),
    .stat (stat),
    .prod (prod)
  );

  `MODEXP_ASSERT_NEXT(a_small_mod_zero, in_acc && mod_small, (state == S_DONE) && (r == '0), "modulus 0 or 1 must give zero")
  `MODEXP_ASSERT_NOW(a_unit_active, (state == S_REDUCE) || (state == S_SQUARE) || (state == S_MULT), stat.busy || stat.done, "sequencer waits on an idle multiplier")
  `MODEXP_ASSERT_NOW(a_start_on_idle, req.start, (state == S_IDLE) || stat.done, "multiplier started mid-operation")

endmodule

`default_nettype wire

// ----- rtl/modexp_mulmod.sv -----
// Bit-serial modular multiplier: one multiplier bit per cycle, shift and add.
`timescale 1ns / 1ps
`default_nettype none
`include "modular_exponentiation_macros.svh"

module modexp_mulmod
  import modexp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  mm_req_t          req,
  input  logic [WIDTH-1:0] n,
  output mm_stat_t         stat,
  output logic [WIDTH-1:0] prod
);

  logic             run;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] mult;
  logic [WIDTH-1:0] bsh;

  logic [WIDTH-1:0] addend;
  logic [WIDTH+1:0] t;
  logic [WIDTH+1:0] n1;
  logic [WIDTH+1:0] n2;
  logic [WIDTH-1:0] acc_next;

  // acc <- (2*acc + bit*a) mod n; the sum stays below 3n, so at most 2n comes off
  always_comb begin
    addend = bsh[WIDTH-1] ? mult : '0;
    t      = {1'b0, acc, 1'b0} + {2'b00, addend};
    n1     = {2'b00, n};
    n2     = {1'b0, n, 1'b0};
    if (t >= n2) begin
      acc_next = WIDTH'(t - n2);
    end else if (t >= n1) begin
      acc_next = WIDTH'(t - n1);
    end else begin
      acc_next = WIDTH'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= CNT_W'(WIDTH - 1);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc  <= '0;
      mult <= req.a;
      bsh  <= req.b;
    end else if (run) begin
      acc <= acc_next;
      bsh <= {bsh[WIDTH-2:0], 1'b0};
    end
  end

  assign stat.busy = run;
  assign stat.done = done;
  assign prod      = acc;

  `MODEXP_ASSERT_NOW(a_no_restart, req.start, !run, "multiplier restarted while busy")
  `MODEXP_ASSERT_NEXT(a_done_once, done, !done, "done held for more than one cycle")
  `MODEXP_ASSERT_NOW(a_acc_reduced, run && (n > WIDTH'(1)), acc < n, "partial product not reduced")

endmodule

`default_nettype wire

// ----- sim/modular_exponentiation_checker.sv -----
// Checker for the modular exponentiation block: predicts each result and compares it.
`timescale 1ns / 1ps

module modular_exponentiation_checker
  import modexp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [FIELD_W-1:0] modulus,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [FIELD_W-1:0] base,
  input  logic [FIELD_W-1:0] exponent,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [FIELD_W-1:0] result,
  output int                 pending,
  output int                 errors
);

  localparam logic [FIELD_W-1:0] RESET_MODULUS = 21;
  localparam int                 REPORT_MAX    = 10;

  typedef struct {
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] exponent;
    logic [FIELD_W-1:0] modulus;
    logic [FIELD_W-1:0] power;
  } power_job_t;

  power_job_t         pending_powers[$];
  logic [FIELD_W-1:0] modulus_copy;
  int                 mismatches;

  // Square-and-multiply, reduced after every step; a zero modulus yields zero.
  function automatic logic [FIELD_W-1:0] power_mod(input logic [FIELD_W-1:0] b,
                                                   input logic [FIELD_W-1:0] e,
                                                   input logic [FIELD_W-1:0] n);
    bit [2*WIDTH-1:0] acc;
    bit [2*WIDTH-1:0] rb;
    bit [2*WIDTH-1:0] rn;
    if (n[WIDTH-1:0] == 0) return '0;
    rn  = n[WIDTH-1:0];
    rb  = b[WIDTH-1:0] % rn;
    acc = 1 % rn;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      acc = (acc * acc) % rn;
      if (e[i]) acc = (acc * rb) % rn;
    end
    return acc[FIELD_W-1:0];
  endfunction

  function automatic void note_mismatch();
    mismatches++;
  endfunction

  initial begin
    modulus_copy = RESET_MODULUS;
    mismatches   = 0;
    pending      = 0;
    errors       = 0;
  end

  always @(posedge clk) begin
    power_job_t job;
    if (rst) begin
      pending_powers.delete();
      modulus_copy = RESET_MODULUS;
    end else begin
      // Retire a result against the oldest expectation.
      if (out_valid && out_ready) begin
        if (pending_powers.size() == 0) begin
          note_mismatch();
          if (mismatches <= REPORT_MAX)
            $display("%0t: result 0x%08h with no item outstanding", $realtime, result);
        end else begin
          job = pending_powers.pop_front();
          if (result !== job.power) begin
            note_mismatch();
            if (mismatches <= REPORT_MAX)
              $display("%0t: 0x%08h ^ 0x%08h mod 0x%08h: expected 0x%08h, got 0x%08h",
                       $realtime, job.base, job.exponent, job.modulus, job.power, result);
          end
        end
      end
      // Predict from the modulus in force when the item is taken.
      if (in_valid && in_ready) begin
        job.base     = base;
        job.exponent = exponent;
        job.modulus  = modulus_copy;
        job.power    = power_mod(base, exponent, modulus_copy);
        pending_powers.push_back(job);
      end
      if (cfg_valid && cfg_ready) modulus_copy = modulus;
    end
    pending <= pending_powers.size();
    errors  <= mismatches;
  end

endmodule

// ----- sim/modular_exponentiation_tb.sv -----
// Testbench top for the modular exponentiation block: stimulus, idling and verdict.
`timescale 1ns / 1ps

module modular_exponentiation_tb;
  import modexp_pkg::*;

  // Allow for the slowest item plus the longest stall on either side, several
  // times over, before declaring the block hung.
  localparam int WATCHDOG_LIMIT = 20000;
  // After the last result, wait about one worst-case item for stray output.
  localparam int TAIL_CYCLES    = 2200;
  localparam int PHASE_ITEMS    = 27;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [FIELD_W-1:0] modulus;
  logic               in_valid;
  logic               in_ready;
  logic [FIELD_W-1:0] base;
  logic [FIELD_W-1:0] exponent;
  logic               out_valid;
  logic               out_ready;
  logic [FIELD_W-1:0] result;

  int pending;
  int errors;
  // When set, both sides run without gaps.
  bit quiet;

  modular_exponentiation u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .modulus   (modulus),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .base      (base),
    .exponent  (exponent),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  modular_exponentiation_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .modulus   (modulus),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .base      (base),
    .exponent  (exponent),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result),
    .pending   (pending),
    .errors    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly zero or short, now and then long.
  function automatic int pick_gap();
    int pick;
    if (quiet) return 0;
    pick = $urandom_range(0, 9);
    if (pick < 6) return $urandom_range(0, 3);
    if (pick < 9) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // Bases: edges around the modulus, both ends of the field, and random values.
  function automatic logic [FIELD_W-1:0] pick_base(input logic [FIELD_W-1:0] n);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 1;
      2:       return n;
      3:       return n - 1;
      4:       return '1;
      5:       return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // Exponents: zero, one, tiny, all ones, single bits, and random values.
  function automatic logic [FIELD_W-1:0] pick_exponent();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 1;
      2:       return $urandom_range(2, 15);
      3:       return '1;
      4:       return FIELD_W'(1) << $urandom_range(0, FIELD_W - 1);
      default: return $urandom;
    endcase
  endfunction

  // Offer one item after an optional gap; hold it until the block takes it.
  task automatic send_item(input logic [FIELD_W-1:0] b, input logic [FIELD_W-1:0] e);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    base     <= b;
    exponent <= e;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every outstanding result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write the modulus only once the block is idle.
  task automatic set_modulus(input logic [FIELD_W-1:0] n);
    drain();
    cfg_valid <= 1'b1;
    modulus   <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: ready runs of random length broken by stalls.
  initial begin
    int run;
    int gap;
    out_ready <= 1'b0;
    forever begin
      run = quiet ? 50 : $urandom_range(1, 20);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if no channel moves an item for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [FIELD_W-1:0] phase_moduli[10];
    logic [FIELD_W-1:0] n;

    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    modulus   <= '0;
    in_valid  <= 1'b0;
    base      <= '0;
    exponent  <= '0;
    quiet     = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed items against the reset modulus of 21.
    send_item(32'd0, 32'd0);             // zero to the zero gives one
    send_item(32'd0, 32'd1);
    send_item(32'd1, 32'd0);
    send_item(32'd20, 32'd2);            // base just below the modulus
    send_item(32'd21, 32'd5);            // base equal to the modulus
    send_item(32'd22, 32'd1);            // exponent one: base reduced
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'd0);
    send_item(32'hFFFF_FFFF, 32'd1);
    send_item(32'd5, 32'h8000_0000);     // only the top exponent bit set
    send_item(32'd2, 32'hFFFF_FFFF);
    send_item(32'd0, 32'hFFFF_FFFF);
    send_item(32'd13, 32'd1);
    send_item(32'd7, 32'd3);
    send_item(32'h1234_5678, 32'hAAAA_AAAA);
    send_item(32'hAAAA_AAAA, 32'h5555_5555);

    // Modulus settings: reset value, both extremes, the degenerate zero and
    // one, a power of two and random values of every size.
    phase_moduli[0] = 32'd21;
    phase_moduli[1] = 32'd2;
    phase_moduli[2] = 32'hFFFF_FFFF;
    phase_moduli[3] = 32'd0;
    phase_moduli[4] = 32'd1;
    phase_moduli[5] = $urandom;
    phase_moduli[6] = $urandom_range(3, 1000);
    phase_moduli[7] = 32'h8000_0000;
    phase_moduli[8] = $urandom;
    phase_moduli[9] = 32'd3;

    foreach (phase_moduli[p]) begin
      n = phase_moduli[p];
      // Phase zero keeps the reset modulus; the rest write the register.
      if (p != 0) set_modulus(n);
      quiet = (p % 3 == 2);
      repeat (PHASE_ITEMS) send_item(pick_base(n), pick_exponent());
    end

    quiet = 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
